// ----- design/salc_pkg.sv -----
package salc_pkg;

  localparam int MAX_SET_BITS = 10;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W        = 3;
  localparam int AGE_MAX      = 7;
  localparam int TAG_W        = 63;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;

  // configuration register widths and indexes
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 4;
  localparam int OFFSET_W     = 6;
  localparam int WAYS_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = CFG_IDX_W'(2);

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST    = SET_BITS_W'(4);
  localparam logic [OFFSET_W-1:0]   OFFSET_BITS_RST = OFFSET_W'(4);
  localparam logic [WAYS_W-1:0]     WAYS_RST        = WAYS_W'(1);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_IFETCH = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic             first_hit;
    logic             evicted;
    logic             second_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ifetch;
  } ctl_sts_t;

endpackage

// ----- design/salc_if.sv -----
interface salc_req_if;
  import salc_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/salc_ram.sv -----
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/salc_ctrl.sv -----
module salc_ctrl
  import salc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !sts.ifetch) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // instruction fetches are taken and dropped here
        cmd.load = in_valid && !sts.ifetch;
      end
      ST_UPDATE: begin
        // hold the set until the result slot is free
        cmd.commit = !out_valid || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_next = cmd.commit | (out_valid & ~out_ready);

endmodule

// ----- design/salc_dpath.sv -----
module salc_dpath
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  req_t                  req_word,
  output rsp_t                  rsp_word,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts
);

  localparam logic [SET_W-1:0] SET_ONES = '1;

  logic [SET_BITS_W-1:0] set_bits;
  logic [OFFSET_W-1:0]   offset_bits;
  logic [WAYS_W-1:0]     ways;

  logic [SET_BITS_W-1:0] sb_eff;
  logic [WAYS_W-1:0]     nw_eff;
  logic [ADDR_W-1:0]     addr_sh;
  logic [SET_W-1:0]      set_idx;
  logic [OFFSET_W:0]     tag_shift;
  logic [ADDR_W-1:0]     addr_tag;

  logic [SET_W-1:0]      set_q;
  logic [TAG_W-1:0]      tag_q;
  logic                  modify_q;
  logic [SET_W-1:0]      clr_addr;

  row_t                  row;
  row_t                  row_new;
  logic                  ram_we;
  logic [SET_W-1:0]      ram_waddr;
  row_t                  ram_wdata;

  logic [MAX_WAYS-1:0]   active;
  logic [MAX_WAYS-1:0]   match;
  logic [MAX_WAYS-1:0]   free;
  logic                  hit;
  logic                  placed;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      victim_way;
  logic [AGE_W-1:0]      best_age;
  logic [WAY_W-1:0]      way;
  logic [AGE_W:0]        old_age;

  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;
  logic [CNT_W-1:0]      eviction_count;
  logic [CNT_W-1:0]      hit_count_next;
  logic [CNT_W-1:0]      miss_count_next;
  logic [CNT_W-1:0]      eviction_count_next;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [CNT_W+1:0] sum;
    sum = {2'b00, cnt} + {{CNT_W{1'b0}}, inc};
    return (sum[CNT_W+1:CNT_W] != 2'b00) ? '1 : sum[CNT_W-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= SET_BITS_RST;
      offset_bits <= OFFSET_BITS_RST;
      ways        <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:    set_bits    <= cfg_data[SET_BITS_W-1:0];
        REG_OFFSET_BITS: offset_bits <= cfg_data[OFFSET_W-1:0];
        REG_WAYS:        ways        <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sb_eff = (set_bits > SET_BITS_W'(MAX_SET_BITS)) ? SET_BITS_W'(MAX_SET_BITS) : set_bits;
    if (ways == '0) begin
      nw_eff = WAYS_W'(1);
    end else if (ways > WAYS_W'(MAX_WAYS)) begin
      nw_eff = WAYS_W'(MAX_WAYS);
    end else begin
      nw_eff = ways;
    end
  end

  // index and tag split of the incoming address
  assign addr_sh   = req_word.address >> offset_bits;
  assign set_idx   = addr_sh[SET_W-1:0] & ~(SET_ONES << sb_eff);
  assign tag_shift = {1'b0, offset_bits} + (OFFSET_W+1)'(sb_eff);
  assign addr_tag  = req_word.address >> tag_shift;

  assign sts.ifetch     = (req_word.mode == MODE_IFETCH);
  assign sts.clear_last = (clr_addr == SET_W'(NUM_SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_q    <= set_idx;
      tag_q    <= addr_tag[TAG_W-1:0];
      modify_q <= (req_word.mode == MODE_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  // way lookup over the row read for this access
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      active[i] = (WAYS_W'(i) < nw_eff);
      match[i]  = active[i] && row[i].valid && (row[i].tag == tag_q);
      free[i]   = active[i] && !row[i].valid;
    end
    hit    = |match;
    placed = |free;
    hit_way  = '0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free[i]) begin
        free_way = WAY_W'(i);
      end
    end
    // oldest line, lowest way on a tie
    best_age   = '0;
    victim_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (active[i] && (row[i].age > best_age)) begin
        best_age   = row[i].age;
        victim_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (placed) begin
      way = free_way;
    end else begin
      way = victim_way;
    end
    // a fresh fill ages every valid line
    old_age = (!hit && placed) ? (AGE_W+1)'(AGE_MAX + 1) : {1'b0, row[way].age};
    row_new = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (active[i] && (WAY_W'(i) != way) && row[i].valid &&
          ({1'b0, row[i].age} < old_age) && (row[i].age < AGE_W'(AGE_MAX))) begin
        row_new[i].age = row[i].age + AGE_W'(1);
      end
    end
    row_new[way].age = '0;
    if (!hit) begin
      row_new[way].valid = 1'b1;
      row_new[way].tag   = tag_q;
    end
  end

  assign ram_we    = cmd.commit | cmd.clear;
  assign ram_waddr = cmd.clear ? clr_addr : set_q;
  assign ram_wdata = cmd.clear ? row_t'('0) : row_new;

  salc_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.load),
    .rd_addr (set_idx),
    .rd_data (row)
  );

  assign hit_count_next      = sat_add(hit_count, {1'b0, hit} + {1'b0, modify_q});
  assign miss_count_next     = sat_add(miss_count, {1'b0, !hit});
  assign eviction_count_next = sat_add(eviction_count, {1'b0, !hit && !placed});

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
    end else if (cmd.commit) begin
      hit_count      <= hit_count_next;
      miss_count     <= miss_count_next;
      eviction_count <= eviction_count_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_word.first_hit      <= hit;
      rsp_word.evicted        <= !hit && !placed;
      rsp_word.second_hit     <= modify_q;
      rsp_word.hit_total      <= hit_count_next;
      rsp_word.miss_total     <= miss_count_next;
      rsp_word.eviction_total <= eviction_count_next;
    end
  end

endmodule

// ----- design/set_assoc_lru_cache_hit_miss_core.sv -----
// Set-associative cache directory with true LRU replacement, up to 1024 sets of up to
// 8 ways. Each load, store or modify word returns one result word with hit, eviction and
// modify flags and the saturating hit, miss and eviction totals; instruction fetches are
// accepted and give no result. A load, store or modify first reads the set's row of tags,
// ages and valid bits from the directory RAM, then compares and writes the updated row
// back; an instruction fetch is only accepted. The RAM is read and written once per
// access, so accesses are handled one at a time. After reset a clearing pass zeroes
// all 1024 sets of the directory, one set per cycle, before the first word is accepted;
// configuration writes must be made only while no access is in flight, as the block
// itself does not enforce it. A finished result waits in an output register and the
// next word can be taken meanwhile, though its update waits until that result is taken.
module set_assoc_lru_cache_hit_miss_core
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  salc_req_if.sink              req,
  salc_rsp_if.source            rsp
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  salc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_word  (req.payload),
    .rsp_word  (rsp.payload),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- tb/tb_set_assoc_lru_cache_hit_miss_core.sv -----
import salc_pkg::*;

class cache_dir_scoreboard;
  bit               line_on  [NUM_SETS*MAX_WAYS];
  logic [TAG_W-1:0] line_tag [NUM_SETS*MAX_WAYS];
  int unsigned      line_age [NUM_SETS*MAX_WAYS];
  bit [CNT_W-1:0]   hits, misses, evictions;
  int unsigned      set_bits_q, offset_q, ways_q;
  rsp_t             awaited[$];
  int               errors;

  function new();
    set_bits_q = SET_BITS_RST;
    offset_q   = OFFSET_BITS_RST;
    ways_q     = WAYS_RST;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SET_BITS:    set_bits_q = data[SET_BITS_W-1:0];
      REG_OFFSET_BITS: offset_q   = data[OFFSET_W-1:0];
      REG_WAYS:        ways_q     = data[WAYS_W-1:0];
      default: ;
    endcase
  endfunction

  function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // make a way the youngest; valid ways younger than its old age grow older
  function void promote(int unsigned base, int unsigned nw, int unsigned way,
                        int unsigned old_age);
    int unsigned k;
    for (int unsigned i = 0; i < nw; i++) begin
      k = base + i;
      if (i != way && line_on[k] && line_age[k] < old_age && line_age[k] < AGE_MAX)
        line_age[k]++;
    end
    line_age[base+way] = 0;
  endfunction

  function void note_access(req_t r);
    int unsigned      sb, nw, shift, set_idx, base, way, best;
    logic [TAG_W-1:0] tag_v;
    bit               hit, placed, evict;
    rsp_t             e;
    if (r.mode == MODE_IFETCH) return;
    hit = 0;
    placed = 0;
    evict = 0;
    sb = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
    nw = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
    set_idx = int'((r.address >> offset_q) & ((64'd1 << sb) - 64'd1));
    shift = offset_q + sb;
    tag_v = (shift >= 64) ? '0 : TAG_W'(r.address >> shift);
    base = set_idx * MAX_WAYS;
    way = 0;
    for (int unsigned i = 0; i < nw; i++) begin
      if (line_on[base+i] && line_tag[base+i] == tag_v) begin
        way = i;
        hit = 1;
        break;
      end
    end
    if (hit) begin
      promote(base, nw, way, line_age[base+way]);
      hits = bump(hits);
    end else begin
      for (int unsigned i = 0; i < nw; i++) begin
        if (!line_on[base+i]) begin
          way = i;
          placed = 1;
          break;
        end
      end
      if (!placed) begin
        // oldest way, lowest index on a tie
        best = 0;
        way = 0;
        for (int unsigned i = 0; i < nw; i++) begin
          if (line_age[base+i] > best) begin
            best = line_age[base+i];
            way = i;
          end
        end
        evict = 1;
        evictions = bump(evictions);
        promote(base, nw, way, line_age[base+way]);
      end else begin
        promote(base, nw, way, AGE_MAX + 1);
      end
      line_on[base+way] = 1;
      line_tag[base+way] = tag_v;
      misses = bump(misses);
    end
    if (r.mode == MODE_MODIFY) hits = bump(hits);
    e.first_hit      = hit;
    e.evicted        = evict;
    e.second_hit     = (r.mode == MODE_MODIFY);
    e.hit_total      = hits;
    e.miss_total     = misses;
    e.eviction_total = evictions;
    awaited.push_back(e);
  endfunction

  function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
    end
  endfunction

  function void check_result(rsp_t got);
    rsp_t e;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word: expected none, got %h", $time, got);
      return;
    end
    e = awaited.pop_front();
    compare_field("first_hit", CNT_W'(e.first_hit), CNT_W'(got.first_hit));
    compare_field("evicted", CNT_W'(e.evicted), CNT_W'(got.evicted));
    compare_field("second_hit", CNT_W'(e.second_hit), CNT_W'(got.second_hit));
    compare_field("hit_total", e.hit_total, got.hit_total);
    compare_field("miss_total", e.miss_total, got.miss_total);
    compare_field("eviction_total", e.eviction_total, got.eviction_total);
  endfunction
endclass

module tb_set_assoc_lru_cache_hit_miss_core;
  localparam int WATCHDOG_LIMIT  = 6000;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE          = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int NUM_PHASES      = 11;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  salc_req_if req();
  salc_rsp_if rsp();

  set_assoc_lru_cache_hit_miss_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  cache_dir_scoreboard board = new();

  int idle_cycles = 0;
  bit hold_rsp = 0;
  bit send_burst = 0;
  bit take_burst = 0;
  int cur_sb = SET_BITS_RST;
  int cur_off = OFFSET_BITS_RST;
  int cur_ways = WAYS_RST;

  // phase settings after the defaults; the last phase draws its own
  int phase_sb   [NUM_PHASES-1] = '{1, 10, 0, 15, 3, 2, 2, 6, 10, 5};
  int phase_off  [NUM_PHASES-1] = '{1, 32, 0, 63, 60, 5, 5, 12, 1, 20};
  int phase_ways [NUM_PHASES-1] = '{2, 8, 4, 15, 0, 8, 3, 6, 8, 2};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (req.valid && req.ready) board.note_access(req.payload);
    if (rsp.valid && rsp.ready) board.check_result(rsp.payload);
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_set_assoc_lru_cache_hit_miss_core: FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [63:0] build_addr(logic [TAG_W-1:0] t, int s);
    logic [63:0] a;
    a = {$urandom, $urandom} & ((64'd1 << cur_off) - 64'd1);
    a |= 64'(s) << cur_off;
    if (cur_off + cur_sb < 64) a |= 64'(t) << (cur_off + cur_sb);
    return a;
  endfunction

  // response side: random back-pressure, one long hold on request
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(take_burst);
      if (hold_rsp) begin
        gap = LONG_HOLD;
        hold_rsp = 0;
      end
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  task automatic send_access(mode_t m, logic [63:0] a);
    int   gap;
    req_t w;
    gap = draw_gap(send_burst);
    w.mode = m;
    w.address = a;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= w;
    do @(posedge clk); while (!req.ready);
  endtask

  // ifetch words give no result, so the drain ends with a settle wait after the last one
  task automatic drain();
    req.valid <= 1'b0;
    // let the monitor note the word taken at the last edge
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(int sb, int off, int w);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: begin
          idx = REG_SET_BITS;
          data = {2'($urandom), 4'(sb)};
        end
        1: begin
          idx = REG_OFFSET_BITS;
          data = 6'(off);
        end
        default: begin
          idx = REG_WAYS;
          data = {2'($urandom), 4'(w)};
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      board.write_reg(idx, data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_sb = (sb > MAX_SET_BITS) ? MAX_SET_BITS : sb;
    cur_off = off;
    cur_ways = (w == 0) ? 1 : ((w > MAX_WAYS) ? MAX_WAYS : w);
  endtask

  // a few sets and a tag pool just larger than the ways, so hits and evictions mix
  task automatic run_phase(int n, int pause_at, int hold_at);
    logic [TAG_W-1:0] tag_pool [16];
    int               set_pool [3];
    int               tag_count, done, roll, set_max;
    mode_t            m;
    logic [63:0]      a;
    bit               paused;
    tag_count = cur_ways + 1 + $urandom_range(0, 2);
    for (int i = 0; i < 16; i++)
      tag_pool[i] = (i < 3) ? TAG_W'(i) : TAG_W'({$urandom, $urandom});
    set_max = (1 << cur_sb) - 1;
    set_pool[0] = 0;
    set_pool[1] = set_max;
    set_pool[2] = $urandom_range(0, set_max);
    done = 0;
    paused = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      m = (roll < 8) ? MODE_IFETCH : mode_t'(2'($urandom_range(0, 2)));
      if ($urandom_range(0, 99) < 15)
        a = {$urandom, $urandom};
      else
        a = build_addr(tag_pool[$urandom_range(0, tag_count - 1)],
                       set_pool[$urandom_range(0, 2)]);
      if (done == pause_at && !paused) begin
        paused = 1;
        drain();
      end
      if (done == hold_at) hold_rsp = 1;
      send_access(m, a);
      if (m != MODE_IFETCH) done++;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SET_BITS;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.payload <= '0;
    rsp.ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default setting: one way, sixteen sets of sixteen-byte lines
    send_access(MODE_IFETCH, 64'h0);
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_LOAD, 64'h0);
    send_access(MODE_STORE, 64'h8);
    send_access(MODE_MODIFY, 64'h100);
    send_access(MODE_MODIFY, 64'h100);
    send_access(MODE_LOAD, '1);
    send_access(MODE_STORE, '1);
    send_access(MODE_LOAD, 64'h8000_0000_0000_00f0);
    send_access(MODE_IFETCH, '1);
    send_access(MODE_LOAD, 64'h10);
    send_access(MODE_STORE, 64'h7fff_ffff_ffff_fff0);

    // two ways: lru order decides the victim
    drain();
    configure(1, 1, 2);
    send_access(MODE_LOAD, 64'h4);
    send_access(MODE_LOAD, 64'h8);
    send_access(MODE_STORE, 64'h4);
    send_access(MODE_LOAD, 64'hc);
    send_access(MODE_MODIFY, 64'h8);
    send_access(MODE_LOAD, 64'hc);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < NUM_PHASES - 1)
        configure(phase_sb[p], phase_off[p], phase_ways[p]);
      else
        configure($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 15));
      run_phase(ITEMS_PER_PHASE, (p == 4) ? 20 : -1, (p == 1) ? 10 : -1);
    end
    drain();

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("tb_set_assoc_lru_cache_hit_miss_core: PASS");
    end else begin
      if (board.awaited.size() != 0)
        $display("%0t: %0d result words never arrived", $time, board.awaited.size());
      $display("tb_set_assoc_lru_cache_hit_miss_core: FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/salc_pkg.sv
design/salc_if.sv
design/salc_ram.sv
design/salc_ctrl.sv
design/salc_dpath.sv
design/set_assoc_lru_cache_hit_miss_core.sv
tb/tb_set_assoc_lru_cache_hit_miss_core.sv
